// ===== hdl/b64sd_pkg.sv =====
// ----------------------------------------------------------------------------
// b64sd_pkg
// shared types and constants of the base64 stream decoder
// ----------------------------------------------------------------------------
package b64sd_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_TRAIL   = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       end_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] push_cnt;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic [5:0] sextet;
    logic       ok;
  } sextet_t;

endpackage

// ===== hdl/b64sd_lookup.sv =====
// ----------------------------------------------------------------------------
// b64sd_lookup
// maps a character code to its six-bit value for both alphabets
// ----------------------------------------------------------------------------
module b64sd_lookup
  import b64sd_pkg::*;
(
  input  logic [7:0] text_char,
  output sextet_t    sx
);

  always_comb begin
    sx.ok     = 1'b1;
    sx.sextet = 6'd0;
    if (text_char >= 8'h41 && text_char <= 8'h5A) begin
      sx.sextet = 6'(text_char - 8'h41);
    end else if (text_char >= 8'h61 && text_char <= 8'h7A) begin
      sx.sextet = 6'(text_char - 8'h61 + 8'd26);
    end else if (text_char >= 8'h30 && text_char <= 8'h39) begin
      sx.sextet = 6'(text_char - 8'h30 + 8'd52);
    end else if (text_char == 8'h2B || text_char == 8'h2D) begin
      sx.sextet = 6'd62;
    end else if (text_char == 8'h2F || text_char == 8'h5F) begin
      sx.sextet = 6'd63;
    end else begin
      sx.ok = 1'b0;
    end
  end

endmodule

// ===== hdl/b64sd_core.sv =====
// ----------------------------------------------------------------------------
// b64sd_core
// group state of the decoder; turns one accepted request into its results
// ----------------------------------------------------------------------------
module b64sd_core
  import b64sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] text_char,
  input  logic       final_char,
  output push_t      push
);

  sextet_t    sx;
  logic [1:0] group_position, group_position_next;
  logic [5:0] held_sextet, held_sextet_next;
  logic       first_char_bad, first_char_bad_next;
  logic       padding_mode, padding_mode_next;
  logic       third_was_pad, third_was_pad_next;
  logic [1:0] fault_code, fault_code_next;
  logic       emit;
  logic [7:0] byte_val;
  logic       pad;
  result_t    data_res;
  result_t    stat_res;

  b64sd_lookup u_lookup (
    .text_char (text_char),
    .sx        (sx)
  );

  assign pad = (text_char == PAD_CHAR);

  always_comb begin
    group_position_next = group_position;
    held_sextet_next    = held_sextet;
    first_char_bad_next = first_char_bad;
    padding_mode_next   = padding_mode;
    third_was_pad_next  = third_was_pad;
    fault_code_next     = fault_code;
    emit                = 1'b0;
    byte_val            = 8'd0;
    if (fault_code == ST_OK) begin
      if (padding_mode) begin
        if (!pad) fault_code_next = ST_TRAIL;
      end else begin
        case (group_position)
          2'd0: begin
            if (pad) begin
              padding_mode_next = 1'b1;
            end else begin
              held_sextet_next    = sx.sextet;
              first_char_bad_next = !sx.ok;
              if (final_char) fault_code_next = ST_TRAIL;
            end
            group_position_next = 2'd1;
          end
          2'd1: begin
            if (final_char) begin
              fault_code_next = ST_TRAIL;
            end else if (first_char_bad || !sx.ok) begin
              fault_code_next = ST_INVALID;
            end else begin
              emit             = 1'b1;
              byte_val         = {held_sextet, sx.sextet[5:4]};
              held_sextet_next = sx.sextet;
            end
            group_position_next = 2'd2;
          end
          2'd2: begin
            if (pad) begin
              third_was_pad_next = 1'b1;
              if (final_char) fault_code_next = ST_TRAIL;
            end else if (!sx.ok) begin
              fault_code_next = ST_INVALID;
            end else begin
              emit             = 1'b1;
              byte_val         = {held_sextet[3:0], sx.sextet[5:2]};
              held_sextet_next = sx.sextet;
              if (final_char) fault_code_next = ST_TRAIL;
            end
            group_position_next = 2'd3;
          end
          default: begin
            if (third_was_pad) begin
              if (!(final_char && pad)) fault_code_next = ST_TRAIL;
            end else if (pad) begin
              if (!final_char) fault_code_next = ST_TRAIL;
            end else if (!sx.ok) begin
              fault_code_next = ST_INVALID;
            end else begin
              emit     = 1'b1;
              byte_val = {held_sextet[1:0], sx.sextet};
            end
            group_position_next = 2'd0;
            third_was_pad_next  = 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    data_res.is_status  = 1'b0;
    data_res.data_byte  = byte_val;
    data_res.status     = ST_OK;
    data_res.end_of_run = 1'b0;
    stat_res.is_status  = 1'b1;
    stat_res.data_byte  = 8'd0;
    stat_res.status     = fault_code_next;
    stat_res.end_of_run = 1'b1;
    push.push_cnt = {1'b0, emit} + {1'b0, final_char};
    push.first    = emit ? data_res : stat_res;
    push.second   = stat_res;
    if (!accept) push.push_cnt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= 2'd0;
      held_sextet    <= 6'd0;
      first_char_bad <= 1'b0;
      padding_mode   <= 1'b0;
      third_was_pad  <= 1'b0;
      fault_code     <= ST_OK;
    end else if (accept) begin
      if (final_char) begin
        group_position <= 2'd0;
        held_sextet    <= 6'd0;
        first_char_bad <= 1'b0;
        padding_mode   <= 1'b0;
        third_was_pad  <= 1'b0;
        fault_code     <= ST_OK;
      end else begin
        group_position <= group_position_next;
        held_sextet    <= held_sextet_next;
        first_char_bad <= first_char_bad_next;
        padding_mode   <= padding_mode_next;
        third_was_pad  <= third_was_pad_next;
        fault_code     <= fault_code_next;
      end
    end
  end

endmodule

// ===== hdl/b64sd_outq.sv =====
// ----------------------------------------------------------------------------
// b64sd_outq
// small result queue; takes up to two results a cycle, while out_stall is low gives one
// ----------------------------------------------------------------------------
module b64sd_outq
  import b64sd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t head
);

  result_t          entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (count <= CNT_W'(QUEUE_DEPTH - 2));
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.push_cnt != 2'd0) entry[wr_ptr] <= push.first;
    if (push.push_cnt == 2'd2) entry[PTR_W'(wr_ptr + 1'b1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + PTR_W'(push.push_cnt));
      if (pop) rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      count <= CNT_W'(count + CNT_W'(push.push_cnt) - CNT_W'(pop));
    end
  end

endmodule

// ===== hdl/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// streaming base64 decoder, standard and url-safe alphabets, strict padding
// ----------------------------------------------------------------------------
// input channel: one character per request (text_char, final_char), taken
// when in_valid is high and in_stall is low. final_char marks the last
// character of a text.
// output channel: one result per transfer; a data byte (is_status low) or,
// after the last character, a status result with end_of_run high.
// results of a character go into the result queue and leave from its head
// in order. a character yields at most two results.
// throughput: one character per cycle while the output keeps up; the
// output moves one result per cycle while out_stall is low, so a run of
// characters that each yield two results is bounded by the output side. a
// four-entry result queue parts the two sides; in_stall rises when fewer
// than two entries are free.
// reset: clears the group state and empties the queue; the block is ready
// in the cycle after rst falls. while out_stall is high the head result
// holds and characters are taken until fewer than two entries are free.
// ----------------------------------------------------------------------------
module base64_stream_decoder
  import b64sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_char,
  input  logic       final_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_status,
  output logic [7:0] data_byte,
  output logic [1:0] status,
  output logic       end_of_run
);

  logic    accept;
  logic    room;
  push_t   push;
  result_t head;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  b64sd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_char  (text_char),
    .final_char (final_char),
    .push       (push)
  );

  b64sd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign is_status  = head.is_status;
  assign data_byte  = head.data_byte;
  assign status     = head.status;
  assign end_of_run = head.end_of_run;

endmodule

// ===== hdl/b64sd_checker.sv =====
// ----------------------------------------------------------------------------
// b64sd_checker
// port-level checks of the base64 stream decoder
// ----------------------------------------------------------------------------
module b64sd_checker
  import b64sd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       final_char,
  input logic       out_valid,
  input logic       out_stall,
  input logic       is_status,
  input logic [7:0] data_byte,
  input logic [1:0] status,
  input logic       end_of_run
);

  // last character always leaves a result behind
  a_final_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && final_char |=> out_valid)
    else $error("no result after last character");

  a_status_marks_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_status |-> end_of_run && data_byte == 8'd0 && status <= ST_TRAIL)
    else $error("malformed status result");

  a_data_is_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_status |-> !end_of_run && status == ST_OK)
    else $error("malformed data result");

  a_stalled_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(is_status)
      && $stable(status))
    else $error("stalled result changed");

endmodule

bind base64_stream_decoder b64sd_checker u_b64sd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .final_char (final_char),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .is_status  (is_status),
  .data_byte  (data_byte),
  .status     (status),
  .end_of_run (end_of_run)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the base64 stream decoder: characters go in as
// texts with a final mark, every result is checked against a cycle-free
// model of the decoder, under directed texts and random well-formed, broken
// and noisy texts with idle and stall phases on both channels
// ----------------------------------------------------------------------------
module testbench
  import b64sd_pkg::*;
();

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 400;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] text_char;
  logic       final_char;
  logic       out_valid;
  logic       out_stall;
  logic       is_status;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       end_of_run;

  // decoder model state
  logic [1:0] grp_pos;
  logic [5:0] held;
  logic       first_bad;
  logic       pad_mode;
  logic       third_pad;
  logic [1:0] fault;

  result_t    pending_results[$];
  logic [7:0] text_buf[$];
  int         sender_idle_pct;
  int         stall_pct;
  int         error_count;
  int         items_sent;
  int         cycle_count;

  base64_stream_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .text_char  (text_char),
    .final_char (final_char),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_status  (is_status),
    .data_byte  (data_byte),
    .status     (status),
    .end_of_run (end_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  function automatic sextet_t sextet_lookup(input logic [7:0] c);
    sextet_t sx;
    sx.ok = 1'b1;
    sx.sextet = 6'd0;
    if (c >= "A" && c <= "Z") sx.sextet = 6'(c - 8'h41);
    else if (c >= "a" && c <= "z") sx.sextet = 6'(c - 8'h61 + 8'd26);
    else if (c >= "0" && c <= "9") sx.sextet = 6'(c - 8'h30 + 8'd52);
    else if (c == "+" || c == "-") sx.sextet = 6'd62;
    else if (c == "/" || c == "_") sx.sextet = 6'd63;
    else sx.ok = 1'b0;
    return sx;
  endfunction

  task push_byte(input logic [7:0] b);
    result_t r;
    r.is_status  = 1'b0;
    r.data_byte  = b;
    r.status     = ST_OK;
    r.end_of_run = 1'b0;
    pending_results.push_back(r);
  endtask

  task clear_decoder_model();
    grp_pos   = 2'd0;
    held      = 6'd0;
    first_bad = 1'b0;
    pad_mode  = 1'b0;
    third_pad = 1'b0;
    fault     = ST_OK;
  endtask

  task decode_char(input logic [7:0] c, input logic last);
    sextet_t sx;
    result_t r;
    sx = sextet_lookup(c);
    if (fault == ST_OK) begin
      if (pad_mode) begin
        if (c != PAD_CHAR) fault = ST_TRAIL;
      end else begin
        case (grp_pos)
          2'd0: begin
            if (c == PAD_CHAR) begin
              pad_mode = 1'b1;
            end else begin
              held = sx.sextet;
              first_bad = !sx.ok;
              if (last) fault = ST_TRAIL;
            end
            grp_pos = 2'd1;
          end
          2'd1: begin
            if (last) begin
              fault = ST_TRAIL;
            end else if (first_bad || !sx.ok) begin
              fault = ST_INVALID;
            end else begin
              push_byte({held, sx.sextet[5:4]});
              held = sx.sextet;
            end
            grp_pos = 2'd2;
          end
          2'd2: begin
            if (c == PAD_CHAR) begin
              third_pad = 1'b1;
              if (last) fault = ST_TRAIL;
            end else if (!sx.ok) begin
              fault = ST_INVALID;
            end else begin
              push_byte({held[3:0], sx.sextet[5:2]});
              held = sx.sextet;
              if (last) fault = ST_TRAIL;
            end
            grp_pos = 2'd3;
          end
          default: begin
            if (third_pad) begin
              if (!(last && c == PAD_CHAR)) fault = ST_TRAIL;
            end else if (c == PAD_CHAR) begin
              if (!last) fault = ST_TRAIL;
            end else if (!sx.ok) begin
              fault = ST_INVALID;
            end else begin
              push_byte({held[1:0], sx.sextet});
            end
            grp_pos = 2'd0;
            third_pad = 1'b0;
          end
        endcase
      end
    end
    if (last) begin
      r.is_status  = 1'b1;
      r.data_byte  = 8'd0;
      r.status     = fault;
      r.end_of_run = 1'b1;
      pending_results.push_back(r);
      clear_decoder_model();
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, data_byte", data_byte, 0);
      end else begin
        want = pending_results.pop_front();
        if (is_status !== want.is_status)
          report_mismatch("is_status", is_status, want.is_status);
        if (data_byte !== want.data_byte)
          report_mismatch("data_byte", data_byte, want.data_byte);
        if (status !== want.status)
          report_mismatch("status", status, want.status);
        if (end_of_run !== want.end_of_run)
          report_mismatch("end_of_run", end_of_run, want.end_of_run);
      end
    end
  end

  task send_item(input logic [7:0] c, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    text_char  <= c;
    final_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_char(c, last);
    items_sent++;
  endtask

  task send_text();
    foreach (text_buf[i]) send_item(text_buf[i], i == text_buf.size() - 1);
  endtask

  task load_string(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task drain(input int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [7:0] random_data_char();
    int v;
    v = $urandom_range(63);
    if (v < 26) return 8'h41 + 8'(v);
    if (v < 52) return 8'h61 + 8'(v - 26);
    if (v < 62) return 8'h30 + 8'(v - 52);
    if (v == 62) return $urandom_range(1) ? "+" : "-";
    return $urandom_range(1) ? "/" : "_";
  endfunction

  task build_random_text();
    int kind;
    int n;
    int pos;
    text_buf.delete();
    kind = $urandom_range(99);
    if (kind < 60) begin
      // well-formed groups with a random ending
      repeat ($urandom_range(3)) repeat (4) text_buf.push_back(random_data_char());
      case ($urandom_range(3))
        0: ;
        1: begin
          repeat (2) text_buf.push_back(random_data_char());
          repeat (2) text_buf.push_back(PAD_CHAR);
        end
        2: begin
          repeat (3) text_buf.push_back(random_data_char());
          text_buf.push_back(PAD_CHAR);
        end
        default: repeat ($urandom_range(1, 3)) text_buf.push_back(random_data_char());
      endcase
      if (text_buf.size() == 0) text_buf.push_back(random_data_char());
    end else if (kind < 75) begin
      // padding tail, sometimes broken
      repeat ($urandom_range(2)) repeat (4) text_buf.push_back(random_data_char());
      n = text_buf.size();
      repeat ($urandom_range(1, 5)) text_buf.push_back(PAD_CHAR);
      if ($urandom_range(1)) begin
        pos = $urandom_range(n, text_buf.size() - 1);
        text_buf[pos] = $urandom_range(1) ? random_data_char() : 8'($urandom_range(255));
      end
    end else if (kind < 90) begin
      // data mixed with misplaced padding and bad codes
      n = $urandom_range(1, 9);
      repeat (n) begin
        pos = $urandom_range(99);
        if (pos < 70) text_buf.push_back(random_data_char());
        else if (pos < 85) text_buf.push_back(PAD_CHAR);
        else text_buf.push_back(8'($urandom_range(255)));
      end
    end else begin
      repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  task run_random_texts(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      build_random_text();
      send_text();
    end
  endtask

  task test_alphabet_extremes();
    load_string("AZaz09+/-_8=");
    send_text();
  endtask

  task test_single_char_texts();
    load_string("=");
    send_text();
    load_string("A");
    send_text();
  endtask

  task test_invalid_chars();
    load_string(" AA");
    send_text();
    load_string("AA");
    text_buf.push_back(8'hFF);
    text_buf.push_back("A");
    send_text();
  endtask

  task test_padding();
    load_string("Ag==");
    send_text();
    load_string("AA=A=");
    send_text();
  endtask

  task test_steady_stream();
    sender_idle_pct = 0;
    stall_pct = 0;
    run_random_texts(PHASE_ITEMS);
  endtask

  task test_sender_gaps();
    sender_idle_pct = 59;
    stall_pct = 0;
    run_random_texts(PHASE_ITEMS / 2);
    // hold off until every pending result is out
    drain(4);
    run_random_texts(PHASE_ITEMS / 2);
  endtask

  task test_receiver_stall();
    sender_idle_pct = 0;
    stall_pct = 59;
    run_random_texts(PHASE_ITEMS);
  endtask

  task test_both_idle();
    sender_idle_pct = 32;
    stall_pct = 32;
    run_random_texts(PHASE_ITEMS);
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    text_char       = 8'd0;
    final_char      = 1'b0;
    out_stall       = 1'b0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    error_count     = 0;
    items_sent      = 0;
    cycle_count     = 0;
    clear_decoder_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_alphabet_extremes();
    test_single_char_texts();
    test_invalid_chars();
    test_padding();
    test_steady_stream();
    test_sender_gaps();
    test_receiver_stall();
    test_both_idle();

    drain(10);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
